// ===== sv/sstp_pkg.sv =====
// ----------------------------------------------------------------------------
// sstp_pkg: shared types and constants for the status tag parser
// Holds the phase encoding, status bit positions and literal tables.
// ----------------------------------------------------------------------------
package sstp_pkg;

    typedef enum logic [2:0] {
        PH_SEEK   = 3'd0,
        PH_TAG    = 3'd1,
        PH_TYP    = 3'd2,
        PH_NUMPRE = 3'd3,
        PH_NUMDIG = 3'd4,
        PH_STOP   = 3'd5
    } phase_t;

    // Literal selectors.
    localparam logic [2:0] LIT_NONE = 3'd0;
    localparam logic [2:0] LIT_OK   = 3'd1;
    localparam logic [2:0] LIT_FAIL = 3'd2;
    localparam logic [2:0] LIT_CAN  = 3'd3;
    localparam logic [2:0] LIT_JAM  = 3'd4;
    localparam logic [2:0] LIT_RSVD = 3'd5;
    localparam logic [2:0] LIT_PAR  = 3'd6;

    localparam int SB_FAIL = 0;
    localparam int SB_PAR  = 1;
    localparam int SB_PST  = 3;
    localparam int SB_PEN  = 4;
    localparam int SB_SIDE = 5;
    localparam int SB_LFT  = 7;
    localparam int SB_ERR  = 8;
    localparam int SB_CAN  = 9;
    localparam int SB_JAM  = 10;
    localparam int SB_RSVD = 11;

    localparam int QDEPTH = 2;
    localparam int RDEPTH = 7;

    // Front-to-back request: a character or the end mark.
    typedef struct packed {
        logic       last;
        logic [7:0] ch;
    } req_t;

    function automatic logic [7:0] lit_char(input logic [2:0] sel, input logic [2:0] pos);
        logic [7:0] r;
        r = 8'h00;
        case (sel)
            LIT_OK:   r = (pos == 3'd0) ? "O" : (pos == 3'd1) ? "K" : " ";
            LIT_FAIL: r = (pos == 3'd0) ? "F" : (pos == 3'd1) ? "A" :
                          (pos == 3'd2) ? "I" : "L";
            LIT_CAN:  r = (pos == 3'd0) ? "C" : (pos == 3'd1) ? "A" :
                          (pos == 3'd2) ? "N" : " ";
            LIT_JAM:  r = (pos == 3'd0) ? "A" : (pos == 3'd1) ? "D" :
                          (pos == 3'd2) ? "F" : (pos == 3'd3) ? " " :
                          (pos == 3'd4) ? "P" : "J";
            LIT_RSVD: r = (pos == 3'd0) ? "R" : (pos == 3'd1) ? "S" :
                          (pos == 3'd2) ? "V" : "D";
            default:  r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] lit_len(input logic [2:0] sel);
        logic [2:0] r;
        case (sel)
            LIT_OK, LIT_FAIL, LIT_CAN, LIT_RSVD: r = 3'd4;
            LIT_JAM: r = 3'd6;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== sv/sstp_front.sv =====
// ----------------------------------------------------------------------------
// sstp_front: input stage and request queue
// Accepts characters, marks the end of a reply and queues requests for the
// parsing engine.
// ----------------------------------------------------------------------------
module sstp_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                valid,
    input  logic [7:0]          ch,
    output logic                stall,
    output logic                q_valid,
    output sstp_pkg::req_t      q_data,
    input  logic                q_pop
);

    sstp_pkg::req_t mem_reg [sstp_pkg::QDEPTH];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     cnt_reg, cnt_next;
    logic           push;

    assign stall   = (cnt_reg == 2'(sstp_pkg::QDEPTH));
    assign push    = valid && !stall;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + 1'(push);
        rd_ptr_next = rd_ptr_reg + 1'(q_pop);
        cnt_next    = cnt_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg].ch   <= ch;
            mem_reg[wr_ptr_reg].last <= (ch == 8'h00);
        end
    end

endmodule

// ===== sv/sstp_engine.sv =====
// ----------------------------------------------------------------------------
// sstp_engine: tag parsing engine
// Consumes one queued character per cycle while no result is waiting and no
// replay runs, replays buffered number characters at the end of a reply and
// presents the decoded status.
module sstp_engine (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  sstp_pkg::req_t      q_data,
    output logic                q_pop,
    output logic                valid,
    input  logic                stall,
    output logic                parse_ok,
    output logic [1:0]          par_status,
    output logic                page_start,
    output logic                page_end,
    output logic signed [28:0]  page_width,
    output logic signed [28:0]  page_height,
    output logic [1:0]          page_side,
    output logic                left_reported,
    output logic signed [28:0]  pages_left,
    output logic                error_flag,
    output logic [2:0]          condition_flags
);

    sstp_pkg::phase_t phase_reg, phase_next;
    logic [7:0]  tag0_reg, tag0_next, tag1_reg, tag1_next;
    logic [2:0]  cpos_reg, cpos_next;
    logic [2:0]  alive_reg, alive_next;
    logic [28:0] num_reg, num_next;
    logic [2:0]  dig_reg, dig_next;
    logic [1:0]  slot_reg, slot_next;
    logic [2:0]  rcnt_reg, rcnt_next;
    logic [11:0] sb_reg, sb_next;
    logic [28:0] w_reg, w_next, h_reg, h_next, l_reg, l_next;
    logic [7:0]  rstore_reg [sstp_pkg::RDEPTH];
    // Replay control: a copy of the buffer contents is walked one per cycle.
    logic        rp_reg, rp_next;
    logic [2:0]  rp_idx_reg, rp_idx_next;
    logic [2:0]  rp_n_reg, rp_n_next;
    logic [7:0]  rbuf_reg [sstp_pkg::RDEPTH];
    logic        rbuf_load;
    logic        out_valid_reg, out_valid_next;
    logic        clear_all;
    logic        st_wr;
    logic [2:0]  st_idx;
    logic [7:0]  st_dat;

    logic [7:0]  c;
    logic        feed_en;
    logic        sel_lit;
    logic [2:0]  al;

    assign valid = out_valid_reg;
    assign parse_ok        = !sb_reg[sstp_pkg::SB_FAIL];
    assign par_status      = sb_reg[sstp_pkg::SB_PAR +: 2];
    assign page_start      = sb_reg[sstp_pkg::SB_PST];
    assign page_end        = sb_reg[sstp_pkg::SB_PEN];
    assign page_side       = sb_reg[sstp_pkg::SB_SIDE +: 2];
    assign left_reported   = sb_reg[sstp_pkg::SB_LFT];
    assign error_flag      = sb_reg[sstp_pkg::SB_ERR];
    assign condition_flags = {sb_reg[sstp_pkg::SB_RSVD], sb_reg[sstp_pkg::SB_JAM],
                              sb_reg[sstp_pkg::SB_CAN]};
    assign page_width  = w_reg;
    assign page_height = h_reg;
    assign pages_left  = l_reg;

    always_comb
    begin
        phase_next = phase_reg; tag0_next = tag0_reg; tag1_next = tag1_reg;
        cpos_next = cpos_reg; alive_next = alive_reg; num_next = num_reg;
        dig_next = dig_reg; slot_next = slot_reg; rcnt_next = rcnt_reg;
        sb_next = sb_reg; w_next = w_reg; h_next = h_reg; l_next = l_reg;
        rp_next = rp_reg; rp_idx_next = rp_idx_reg; rp_n_next = rp_n_reg;
        rbuf_load = 1'b0; clear_all = 1'b0;
        st_wr = 1'b0; st_idx = rcnt_reg; st_dat = 8'h00;
        out_valid_next = out_valid_reg && stall;
        q_pop = 1'b0; feed_en = 1'b0; c = 8'h00; sel_lit = 1'b0; al = 3'd0;

        if (out_valid_reg && stall)
        begin
            // Result still waiting: hold everything.
        end
        else if (out_valid_reg)
        begin
            clear_all = 1'b1;
        end
        else if (rp_reg)
        begin
            if (rp_idx_reg == rp_n_reg)
                rp_next = 1'b0;
            else
            begin
                feed_en = 1'b1;
                c = rbuf_reg[rp_idx_reg];
                rp_idx_next = rp_idx_reg + 3'd1;
            end
        end
        else if (q_valid)
        begin
            if (!q_data.last)
            begin
                q_pop = 1'b1;
                feed_en = 1'b1;
                c = q_data.ch;
            end
            else
            begin
                // End of reply: resolve pending phase, replay if inside a number.
                case (phase_reg)
                    sstp_pkg::PH_TAG:
                    begin
                        sb_next[sstp_pkg::SB_FAIL] = 1'b1;
                        q_pop = 1'b1; out_valid_next = 1'b1;
                    end
                    sstp_pkg::PH_NUMPRE, sstp_pkg::PH_NUMDIG:
                    begin
                        if (slot_reg == 2'd0)
                        begin
                            w_next = '1; h_next = '1;
                        end
                        else if (slot_reg <= 2'd2)
                            h_next = '1;
                        else
                            l_next = '1;
                        if (phase_reg == sstp_pkg::PH_NUMPRE)
                        begin
                            q_pop = 1'b1; out_valid_next = 1'b1;
                        end
                        else
                        begin
                            rbuf_load = 1'b1;
                            rp_next = 1'b1; rp_idx_next = 3'd0; rp_n_next = rcnt_reg;
                            rcnt_next = 3'd0;
                            phase_next = sstp_pkg::PH_SEEK;
                            alive_next = 3'd0; cpos_next = 3'd0;
                        end
                    end
                    default:
                    begin
                        q_pop = 1'b1; out_valid_next = 1'b1;
                    end
                endcase
            end
        end

        if (feed_en)
        begin
            case (phase_reg)
                sstp_pkg::PH_STOP: ;
                sstp_pkg::PH_TAG:
                begin
                    if (cpos_reg == 3'd0)
                    begin
                        tag0_next = c; cpos_next = 3'd1;
                    end
                    else if (cpos_reg == 3'd1)
                    begin
                        tag1_next = c; cpos_next = 3'd2;
                    end
                    else
                    begin
                        phase_next = sstp_pkg::PH_SEEK;
                        alive_next = sstp_pkg::LIT_NONE; cpos_next = 3'd0;
                        if (tag0_reg == "-" && tag1_reg == "-" && c == "-")
                            phase_next = sstp_pkg::PH_STOP;
                        else if (tag0_reg == "p" && tag1_reg == "a" && c == "r")
                            alive_next = sstp_pkg::LIT_PAR;
                        else if (tag0_reg == "p" && tag1_reg == "s" && c == "t")
                        begin
                            sb_next[sstp_pkg::SB_PST] = 1'b1; slot_next = 2'd0;
                            phase_next = sstp_pkg::PH_NUMPRE;
                        end
                        else if (tag0_reg == "p" && tag1_reg == "e" && c == "n")
                            sb_next[sstp_pkg::SB_PEN] = 1'b1;
                        else if (tag0_reg == "t" && tag1_reg == "y" && c == "p")
                            phase_next = sstp_pkg::PH_TYP;
                        else if (tag0_reg == "l" && tag1_reg == "f" && c == "t")
                        begin
                            sb_next[sstp_pkg::SB_LFT] = 1'b1; slot_next = 2'd3;
                            phase_next = sstp_pkg::PH_NUMPRE;
                        end
                        else if (tag0_reg == "a" && tag1_reg == "t" && c == "n")
                            alive_next = sstp_pkg::LIT_CAN;
                        else if (tag0_reg == "e" && tag1_reg == "r" && c == "r")
                        begin
                            sb_next[sstp_pkg::SB_ERR] = 1'b1; alive_next = sstp_pkg::LIT_JAM;
                        end
                        else if (tag0_reg == "n" && tag1_reg == "r" && c == "d")
                        begin
                            sb_next[sstp_pkg::SB_ERR] = 1'b1; alive_next = sstp_pkg::LIT_RSVD;
                        end
                    end
                end
                sstp_pkg::PH_TYP:
                begin
                    if (c == "A") sb_next[sstp_pkg::SB_SIDE +: 2] = 2'd1;
                    if (c == "B") sb_next[sstp_pkg::SB_SIDE +: 2] = 2'd2;
                    phase_next = sstp_pkg::PH_SEEK;
                    sel_lit = 1'b1;
                end
                sstp_pkg::PH_NUMPRE:
                begin
                    if (c == "d" || c == "i")
                    begin
                        st_wr = 1'b1; st_idx = 3'd0; st_dat = c;
                        rcnt_next = 3'd1; num_next = '0;
                        dig_next = (c == "d") ? 3'd3 : 3'd7;
                        phase_next = sstp_pkg::PH_NUMDIG;
                    end
                    else
                    begin
                        if (slot_reg == 2'd0)
                        begin
                            w_next = '1; h_next = '1;
                        end
                        else if (slot_reg <= 2'd2)
                            h_next = '1;
                        else
                            l_next = '1;
                        phase_next = sstp_pkg::PH_SEEK;
                        sel_lit = 1'b1;
                    end
                end
                sstp_pkg::PH_NUMDIG:
                begin
                    if (rcnt_reg < 3'd7)
                    begin
                        st_wr = 1'b1; st_idx = rcnt_reg; st_dat = c;
                        rcnt_next = rcnt_reg + 3'd1;
                    end
                    num_next = 29'((num_reg << 3) + (num_reg << 1) + 29'(c) - 29'd48);
                    if (dig_reg == 3'd1 || dig_reg == 3'd0)
                    begin
                        dig_next = 3'd0; rcnt_next = 3'd0;
                        if (slot_reg == 2'd0) w_next = num_next;
                        else if (slot_reg == 2'd2) h_next = num_next;
                        else if (slot_reg == 2'd3) l_next = num_next;
                        if (slot_reg < 2'd2)
                        begin
                            slot_next = slot_reg + 2'd1; phase_next = sstp_pkg::PH_NUMPRE;
                        end
                        else
                            phase_next = sstp_pkg::PH_SEEK;
                    end
                    else
                        dig_next = dig_reg - 3'd1;
                end
                default: sel_lit = 1'b1;
            endcase

            if (sel_lit)
            begin
                al = alive_reg;
                if (al != sstp_pkg::LIT_NONE)
                begin
                    if (al == sstp_pkg::LIT_PAR)
                        al = (c == "O") ? sstp_pkg::LIT_OK :
                             (c == "F") ? sstp_pkg::LIT_FAIL : sstp_pkg::LIT_NONE;
                    if (al >= 3'd1 && al <= 3'd5 && cpos_reg < sstp_pkg::lit_len(al)
                        && c == sstp_pkg::lit_char(al, cpos_reg))
                    begin
                        alive_next = al;
                        cpos_next = cpos_reg + 3'd1;
                        if (cpos_next >= sstp_pkg::lit_len(al))
                        begin
                            case (al)
                                sstp_pkg::LIT_OK:   sb_next[sstp_pkg::SB_PAR +: 2] = 2'd1;
                                sstp_pkg::LIT_FAIL: sb_next[sstp_pkg::SB_PAR +: 2] = 2'd2;
                                sstp_pkg::LIT_CAN:  sb_next[sstp_pkg::SB_CAN] = 1'b1;
                                sstp_pkg::LIT_JAM:  sb_next[sstp_pkg::SB_JAM] = 1'b1;
                                sstp_pkg::LIT_RSVD: sb_next[sstp_pkg::SB_RSVD] = 1'b1;
                                default: ;
                            endcase
                            alive_next = 3'd0; cpos_next = 3'd0;
                        end
                    end
                    else
                    begin
                        alive_next = 3'd0; cpos_next = 3'd0;
                    end
                end
                if (c == "#")
                begin
                    phase_next = sstp_pkg::PH_TAG; cpos_next = 3'd0; alive_next = 3'd0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= sstp_pkg::PH_SEEK;
            tag0_reg <= '0; tag1_reg <= '0; cpos_reg <= '0; alive_reg <= '0;
            num_reg <= '0; dig_reg <= '0; slot_reg <= '0; rcnt_reg <= '0;
            sb_reg <= '0; w_reg <= '0; h_reg <= '0; l_reg <= '0;
            rp_reg <= 1'b0; rp_idx_reg <= '0; rp_n_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (clear_all)
        begin
            phase_reg <= sstp_pkg::PH_SEEK;
            tag0_reg <= '0; tag1_reg <= '0; cpos_reg <= '0; alive_reg <= '0;
            num_reg <= '0; dig_reg <= '0; slot_reg <= '0; rcnt_reg <= '0;
            sb_reg <= '0; w_reg <= '0; h_reg <= '0; l_reg <= '0;
            rp_reg <= 1'b0; rp_idx_reg <= '0; rp_n_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            tag0_reg <= tag0_next; tag1_reg <= tag1_next;
            cpos_reg <= cpos_next; alive_reg <= alive_next;
            num_reg <= num_next; dig_reg <= dig_next; slot_reg <= slot_next;
            rcnt_reg <= rcnt_next; sb_reg <= sb_next;
            w_reg <= w_next; h_reg <= h_next; l_reg <= l_next;
            rp_reg <= rp_next; rp_idx_reg <= rp_idx_next; rp_n_reg <= rp_n_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_wr)
            rstore_reg[st_idx] <= st_dat;
        if (rbuf_load)
            rbuf_reg <= rstore_reg;
    end

endmodule

// ===== sv/scanner_status_tag_parser.sv =====
// ----------------------------------------------------------------------------
// scanner_status_tag_parser: status reply tag decoder
// Decodes a scanner status reply, one character per request, into a status.
// ----------------------------------------------------------------------------
// Usage: characters arrive on the input channel (valid, stall, ch), one per
// request. A NUL character ends the reply; the decoded status then appears on
// the output channel (valid_out, stall_out and the status fields) as a
// single request. Non-NUL characters produce no output.
// Throughput: one character per cycle while stall is low. A two-entry
// request queue separates the input stage from the parsing engine, so
// either side may stall alone. With nothing else queued, the NUL is
// registered in the queue and the engine then registers the status.
// The engine clears its state in the cycle a status is taken, and reads
// no character in it. If the reply ends inside a number, the engine
// replays the buffered number characters (up to seven, one per cycle)
// before it resolves the end, and the replay may repeat.
// While the result waits under stall_out, the engine holds; the queue keeps
// taking characters until it is full, then raises stall.
// Reset clears all parser state; after each result the engine returns to the
// same state on its own, ready for the next reply.
// ----------------------------------------------------------------------------
module scanner_status_tag_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                valid,
    output logic                stall,
    input  logic [7:0]          ch,
    output logic                valid_out,
    input  logic                stall_out,
    output logic                parse_ok,
    output logic [1:0]          par_status,
    output logic                page_start,
    output logic                page_end,
    output logic signed [28:0]  page_width,
    output logic signed [28:0]  page_height,
    output logic [1:0]          page_side,
    output logic                left_reported,
    output logic signed [28:0]  pages_left,
    output logic                error_flag,
    output logic [2:0]          condition_flags
);

    logic           q_valid;
    logic           q_pop;
    sstp_pkg::req_t q_data;

    // The front stage queues requests; the engine pops them as it parses.
    sstp_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .valid   (valid),
        .ch      (ch),
        .stall   (stall),
        .q_valid (q_valid),
        .q_data  (q_data),
        .q_pop   (q_pop)
    );

    sstp_engine u_engine (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_valid         (q_valid),
        .q_data          (q_data),
        .q_pop           (q_pop),
        .valid           (valid_out),
        .stall           (stall_out),
        .parse_ok        (parse_ok),
        .par_status      (par_status),
        .page_start      (page_start),
        .page_end        (page_end),
        .page_width      (page_width),
        .page_height     (page_height),
        .page_side       (page_side),
        .left_reported   (left_reported),
        .pages_left      (pages_left),
        .error_flag      (error_flag),
        .condition_flags (condition_flags)
    );

`ifndef SYNTHESIS
    // The engine never pops from an empty queue.
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid) else $error("pop from empty queue");

    // The engine does not consume input while a result is waiting.
    a_hold_on_out: assert property (@(posedge clk) disable iff (!rst_n)
        valid_out |-> !q_pop) else $error("pop while result pending");

    // A stalled result stays presented, with page_width and pages_left unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid_out && stall_out |=> valid_out && $stable(page_width)
        && $stable(pages_left)) else $error("stalled result changed");
`endif

endmodule

// ===== bench/status_reply_checker.sv =====
// ----------------------------------------------------------------------------
// status_reply_checker: decoded status predictor and comparator
// Watches both channels, decodes each reply itself and checks every status.
// ----------------------------------------------------------------------------
module status_reply_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               valid,
    input  logic               stall,
    input  logic [7:0]         ch,
    input  logic               valid_out,
    input  logic               stall_out,
    input  logic               parse_ok,
    input  logic [1:0]         par_status,
    input  logic               page_start,
    input  logic               page_end,
    input  logic signed [28:0] page_width,
    input  logic signed [28:0] page_height,
    input  logic [1:0]         page_side,
    input  logic               left_reported,
    input  logic signed [28:0] pages_left,
    input  logic               error_flag,
    input  logic [2:0]         condition_flags,
    output int                 fail_count,
    output int                 pending
);

    typedef struct packed {
        logic        ok;
        logic [1:0]  par;
        logic        pst;
        logic        pen;
        logic [28:0] wid;
        logic [28:0] hgt;
        logic [1:0]  side;
        logic        lft;
        logic [28:0] left;
        logic        err;
        logic [2:0]  cond;
    } status_t;

    status_t     status_queue[$];

    sstp_pkg::phase_t phase;
    logic [7:0]  tag0, tag1;
    logic [2:0]  cpos, calive;
    logic [31:0] numv;
    logic [2:0]  digits;
    logic [1:0]  slot;
    logic [7:0]  replay[sstp_pkg::RDEPTH];
    logic [2:0]  rcount;
    logic [11:0] sbits;
    logic [31:0] wreg, hreg, lreg;

    function automatic logic [7:0] word_char(input logic [2:0] sel, input logic [2:0] pos);
        string s;
        case (sel)
            sstp_pkg::LIT_OK:   s = "OK  ";
            sstp_pkg::LIT_FAIL: s = "FAIL";
            sstp_pkg::LIT_CAN:  s = "CAN ";
            sstp_pkg::LIT_JAM:  s = "ADF PJ";
            sstp_pkg::LIT_RSVD: s = "RSVD";
            default:            s = "";
        endcase
        return (pos < s.len()) ? s[pos] : 8'h00;
    endfunction

    function automatic logic [2:0] word_len(input logic [2:0] sel);
        return (sel == sstp_pkg::LIT_JAM) ? 3'd6 :
               (sel >= sstp_pkg::LIT_OK && sel <= sstp_pkg::LIT_RSVD) ? 3'd4 : 3'd0;
    endfunction

    task automatic clear_state();
        phase = sstp_pkg::PH_SEEK; tag0 = 0; tag1 = 0; cpos = 0;
        calive = sstp_pkg::LIT_NONE;
        numv = 0; digits = 0; slot = 0; rcount = 0; sbits = 0;
        wreg = 0; hreg = 0; lreg = 0;
    endtask

    task automatic fail_numbers();
        if (slot == 0) begin wreg = '1; hreg = '1; end
        else if (slot <= 2) hreg = '1;
        else lreg = '1;
    endtask

    task automatic take_tag(input logic [7:0] c);
        phase = sstp_pkg::PH_SEEK; calive = sstp_pkg::LIT_NONE; cpos = 0;
        case ({tag0, tag1, c})
            "---": phase = sstp_pkg::PH_STOP;
            "par": calive = sstp_pkg::LIT_PAR;
            "pst":
            begin
                sbits[sstp_pkg::SB_PST] = 1; slot = 0; phase = sstp_pkg::PH_NUMPRE;
            end
            "pen": sbits[sstp_pkg::SB_PEN] = 1;
            "typ": phase = sstp_pkg::PH_TYP;
            "lft":
            begin
                sbits[sstp_pkg::SB_LFT] = 1; slot = 3; phase = sstp_pkg::PH_NUMPRE;
            end
            "atn": calive = sstp_pkg::LIT_CAN;
            "err": begin sbits[sstp_pkg::SB_ERR] = 1; calive = sstp_pkg::LIT_JAM; end
            "nrd": begin sbits[sstp_pkg::SB_ERR] = 1; calive = sstp_pkg::LIT_RSVD; end
            default: ;
        endcase
    endtask

    task automatic hunt(input logic [7:0] c);
        if (calive != sstp_pkg::LIT_NONE) begin
            if (calive == sstp_pkg::LIT_PAR)
                calive = (c == "O") ? sstp_pkg::LIT_OK :
                         (c == "F") ? sstp_pkg::LIT_FAIL : sstp_pkg::LIT_NONE;
            if (calive >= sstp_pkg::LIT_OK && calive <= sstp_pkg::LIT_RSVD
                && cpos < word_len(calive) && c == word_char(calive, cpos)) begin
                cpos++;
                if (cpos >= word_len(calive)) begin
                    case (calive)
                        sstp_pkg::LIT_OK:   sbits[sstp_pkg::SB_PAR +: 2] = 2'd1;
                        sstp_pkg::LIT_FAIL: sbits[sstp_pkg::SB_PAR +: 2] = 2'd2;
                        sstp_pkg::LIT_CAN:  sbits[sstp_pkg::SB_CAN] = 1;
                        sstp_pkg::LIT_JAM:  sbits[sstp_pkg::SB_JAM] = 1;
                        default:            sbits[sstp_pkg::SB_RSVD] = 1;
                    endcase
                    calive = sstp_pkg::LIT_NONE; cpos = 0;
                end
            end else begin
                calive = sstp_pkg::LIT_NONE; cpos = 0;
            end
        end
        if (c == "#") begin
            phase = sstp_pkg::PH_TAG; cpos = 0; calive = sstp_pkg::LIT_NONE;
        end
    endtask

    task automatic scan_char(input logic [7:0] c);
        case (phase)
            sstp_pkg::PH_STOP: ;
            sstp_pkg::PH_TAG:
                if (cpos < 2) begin
                    if (cpos == 0) tag0 = c; else tag1 = c;
                    cpos++;
                end else take_tag(c);
            sstp_pkg::PH_TYP: begin
                if (c == "A") sbits[sstp_pkg::SB_SIDE +: 2] = 2'd1;
                if (c == "B") sbits[sstp_pkg::SB_SIDE +: 2] = 2'd2;
                phase = sstp_pkg::PH_SEEK;
                hunt(c);
            end
            sstp_pkg::PH_NUMPRE:
                if (c == "d" || c == "i") begin
                    replay[0] = c; rcount = 1; numv = 0;
                    digits = (c == "d") ? 3 : 7;
                    phase = sstp_pkg::PH_NUMDIG;
                end else begin
                    fail_numbers();
                    phase = sstp_pkg::PH_SEEK;
                    hunt(c);
                end
            sstp_pkg::PH_NUMDIG: begin
                if (rcount < 7) begin replay[rcount] = c; rcount++; end
                numv = numv * 10 + c - 48;
                if (digits > 0) digits--;
                if (digits == 0) begin
                    rcount = 0;
                    if (slot == 0) wreg = numv;
                    else if (slot == 2) hreg = numv;
                    else if (slot == 3) lreg = numv;
                    if (slot < 2) begin slot++; phase = sstp_pkg::PH_NUMPRE; end
                    else phase = sstp_pkg::PH_SEEK;
                end
            end
            default: hunt(c);
        endcase
    endtask

    // Resolves the end of a reply, replaying a cut-off number as often as needed.
    task automatic end_reply();
        logic [7:0] held[sstp_pkg::RDEPTH];
        int n;
        status_t s;
        forever begin
            if (phase == sstp_pkg::PH_TAG) begin sbits[sstp_pkg::SB_FAIL] = 1; break; end
            if (phase == sstp_pkg::PH_NUMPRE) begin fail_numbers(); break; end
            if (phase != sstp_pkg::PH_NUMDIG) break;
            fail_numbers();
            n = rcount;
            for (int i = 0; i < n; i++) held[i] = replay[i];
            rcount = 0; phase = sstp_pkg::PH_SEEK; calive = sstp_pkg::LIT_NONE; cpos = 0;
            for (int i = 0; i < n; i++) scan_char(held[i]);
        end
        s.ok = !sbits[sstp_pkg::SB_FAIL]; s.par = sbits[sstp_pkg::SB_PAR +: 2];
        s.pst = sbits[sstp_pkg::SB_PST]; s.pen = sbits[sstp_pkg::SB_PEN];
        s.wid = wreg[28:0]; s.hgt = hreg[28:0]; s.side = sbits[sstp_pkg::SB_SIDE +: 2];
        s.lft = sbits[sstp_pkg::SB_LFT]; s.left = lreg[28:0];
        s.err = sbits[sstp_pkg::SB_ERR];
        s.cond = {sbits[sstp_pkg::SB_RSVD], sbits[sstp_pkg::SB_JAM],
                  sbits[sstp_pkg::SB_CAN]};
        status_queue.push_back(s);
        clear_state();
    endtask

    assign pending = status_queue.size();

    always @(posedge clk or negedge rst_n)
    begin
        status_t got, want;
        if (!rst_n)
        begin
            clear_state();
            status_queue.delete();
            fail_count <= 0;
        end
        else
        begin
            if (valid && !stall)
            begin
                if (ch == 8'h00) end_reply();
                else scan_char(ch);
            end
            if (valid_out && !stall_out)
            begin
                got = '{parse_ok, par_status, page_start, page_end, page_width,
                        page_height, page_side, left_reported, pages_left,
                        error_flag, condition_flags};
                if (status_queue.size() == 0)
                begin
                    if (fail_count < 10) $display("unexpected status %h", got);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = status_queue.pop_front();
                    if (got !== want)
                    begin
                        if (fail_count < 10)
                            $display("status mismatch: expected %h, got %h", want, got);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// ===== bench/tb_scanner_status_tag_parser.sv =====
// ----------------------------------------------------------------------------
// tb_scanner_status_tag_parser: testbench for the status tag parser
// Feeds directed and random status replies with random gaps and output
// stalls; a checker beside the block predicts and compares every status.
// ----------------------------------------------------------------------------
module tb_scanner_status_tag_parser;

    // Cycles of inactivity before the run is declared hung. This is generous
    // beside a reply's end plus a full replay and the longest random wait
    // of either side.
    localparam int IDLE_LIMIT = 2000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               valid = 1'b0;
    logic [7:0]         ch = 8'h00;
    logic               stall_out = 1'b0;
    logic               stall;
    logic               valid_out;
    logic               parse_ok;
    logic [1:0]         par_status;
    logic               page_start;
    logic               page_end;
    logic signed [28:0] page_width;
    logic signed [28:0] page_height;
    logic [1:0]         page_side;
    logic               left_reported;
    logic signed [28:0] pages_left;
    logic               error_flag;
    logic [2:0]         condition_flags;
    int                 fail_count;
    int                 pending;
    int                 idle_cycles = 0;
    logic               no_gaps = 1'b0;

    // Characters of all replies still to be sent, NULs included.
    byte unsigned       reply_chars[$];

    always #10 clk = ~clk;

    scanner_status_tag_parser u_dut (.*);

    status_reply_checker u_check (.*);

    // Adds one reply string followed by its terminating NUL.
    task automatic add_reply(input string s);
        for (int i = 0; i < s.len(); i++)
            reply_chars.push_back(s[i]);
        reply_chars.push_back(8'h00);
    endtask

    // Builds a random number field: mostly a well-formed 'd' or 'i' number,
    // sometimes a bad prefix or none at all, and sometimes cut short.
    function automatic string rand_number();
        string s;
        int    n;
        case ($urandom_range(0, 9))
            0: s = "x";
            1: s = "";
            default: s = $urandom_range(0, 1) ? "d" : "i";
        endcase
        n = (s == "d") ? 3 : (s == "i") ? 7 : 0;
        for (int i = 0; i < n; i++)
        begin
            // Any byte counts as a digit, so wide bytes appear now and then.
            if ($urandom_range(0, 7) == 0)
                s = {s, string'(byte'($urandom_range(1, 255)))};
            else
                s = {s, string'(byte'($urandom_range(48, 57)))};
        end
        if ($urandom_range(0, 9) == 0 && s.len() > 1)
            s = s.substr(0, $urandom_range(0, s.len() - 2));
        return s;
    endfunction

    // One random reply: mostly well-formed tags with random contents,
    // mixed with noise and broken sequences.
    function automatic string rand_reply();
        string words[6] = '{"OK  ", "FAIL", "CAN ", "ADF PJ", "RSVD", "OKAY"};
        string tags[10] = '{"par", "pst", "pen", "typ", "lft", "atn", "err", "nrd",
                             "---", "zzz"};
        string s = "";
        string w;
        int    k;
        repeat ($urandom_range(0, 5))
        begin
            k = $urandom_range(0, 13);
            if (k >= 10)
            begin
                // Noise or a tag cut short.
                w = string'(byte'($urandom_range(1, 255)));
                s = {s, (k == 10) ? "#p" : w};
                continue;
            end
            s = {s, "#", tags[k]};
            case (k)
                0, 5, 6, 7:
                begin
                    w = words[$urandom_range(0, 5)];
                    if ($urandom_range(0, 3) == 0)
                        w = w.substr(0, $urandom_range(0, w.len() - 1));
                    s = {s, w};
                end
                1: s = {s, rand_number(), rand_number(), rand_number()};
                3: s = {s, ($urandom_range(0, 2) == 0) ? "A" :
                            ($urandom_range(0, 1) ? "B" : "C")};
                4: s = {s, rand_number()};
                default: ;
            endcase
        end
        return s;
    endfunction

    // True once, when about half of the characters have been sent.
    int sent_mark = -1;
    function automatic logic r_half();
        if (sent_mark < 0)
        begin
            sent_mark = reply_chars.size() / 2;
            return 1'b0;
        end
        if (sent_mark > 0 && reply_chars.size() == sent_mark)
        begin
            sent_mark = 0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Stimulus: directed replies first, then random replies.
    initial
    begin
        int   wait_cycles;
        logic pause;
        add_reply("");
        add_reply("#par OK  #pen");
        add_reply("#parFAIL#typA#pstd123d456i9999999");
        add_reply("#pstd999i0000000d001#typB#lfti1234567");
        add_reply("#atnCAN #errADF PJ#nrdRSVD");
        add_reply("#errADF P");
        add_reply("#pstx#lftd12");
        add_reply("#pstd1");
        add_reply("#lft");
        add_reply("#pa");
        add_reply("#---#pen#lftd123");
        add_reply("#zzz#pen#typC");
        add_reply("#lftd#pe#pstd\377\377\377");
        add_reply("#pstd#lftd001");
        add_reply("\377\200#parOKAY#pstd000d000d000");

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        for (int r = 0; r < 80; r++)
            add_reply(rand_reply());

        while (reply_chars.size() > 0)
        begin
            // Halfway through, hold off until every status has come back.
            pause = r_half();
            wait_cycles = (no_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
            if (pause || wait_cycles != 0)
                valid <= 1'b0;
            if (pause)
            begin
                do @(posedge clk); while (pending != 0);
            end
            repeat (wait_cycles) @(posedge clk);
            valid <= 1'b1;
            ch <= reply_chars.pop_front();
            do @(posedge clk); while (stall);
        end
        valid <= 1'b0;
    end

    // Some stretches run with no gaps and no stalls at all.
    always @(posedge clk)
    begin
        if ($urandom_range(0, 199) == 0)
            no_gaps <= ~no_gaps;
    end

    // After each status is taken, the receiver stalls for a drawn number of cycles, possibly none.
    initial
    begin
        int hold;
        forever
        begin
            @(posedge clk);
            if (valid_out && !stall_out)
            begin
                hold = no_gaps ? 0 : $urandom_range(0, 19);
                if (hold != 0)
                begin
                    stall_out <= 1'b1;
                    repeat (hold) @(posedge clk);
                    stall_out <= 1'b0;
                end
            end
        end
    end

    // Watchdog and end of run.
    always @(posedge clk)
    begin
        if ((valid && !stall) || (valid_out && !stall_out) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        wait (rst_n);
        wait (reply_chars.size() == 0 && !valid && pending == 0);
        repeat (50) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
